// File: rtl/dfa_substring_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DFA substring search core.
// Both macros sample on the rising edge of i_clk in the using scope.
// ----------------------------------------------------------------------------
`ifndef DFA_SUBSTRING_SEARCH_CORE_ASSERT_SVH
`define DFA_SUBSTRING_SEARCH_CORE_ASSERT_SVH

// Checked at every edge, reset included.
`define DSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked only while reset is released.
`define DSS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// File: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the DFA substring search core.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned STATE_IN_W = 4;
    localparam int unsigned SYMBOL_W   = 8;
    localparam int unsigned START_W    = 4;
    localparam int unsigned ACCEPT_W   = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_TEXT  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_STATE = 1'b0,
        CFG_ACCEPT_MASK = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

// File: rtl/dfa_substring_search_core.sv
// ----------------------------------------------------------------------------
// dfa_substring_search_core
// Unanchored DFA search over a text stream with a banked route table.
// ----------------------------------------------------------------------------
// Pipeline: an accepted text beat is registered into stage two with its table reads,
// and its result into the output register. Throughput: one beat per cycle while
// o_in_stall is low; each byte reads every state bank once at the byte address, and the
// live-run register closes its own loop. Reset and the clear action start a sweep over
// every table address that invalidates the table; o_in_stall is high during it, config writes go on.
// ----------------------------------------------------------------------------
`default_nettype none

module dfa_substring_search_core #(
    parameter int unsigned NUM_STATES  = 16,
    parameter int unsigned SYMBOL_BITS = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [dss_pkg::ACTION_W-1:0]     i_action,
    input  wire  [dss_pkg::STATE_IN_W-1:0]   i_state_from,
    input  wire  [dss_pkg::SYMBOL_W-1:0]     i_symbol,
    input  wire  [dss_pkg::STATE_IN_W-1:0]   i_state_to,
    input  wire                              i_line_last,
    // Output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_hit,
    output logic                             o_found,
    output logic                             o_line_end,
    // Configuration
    input  wire                              i_cfg_we,
    input  wire  [dss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [dss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dss_pkg::*;

    localparam int unsigned SW    = $clog2(NUM_STATES);
    localparam int unsigned DEPTH = 1 << SYMBOL_BITS;
    localparam int unsigned EW    = SW + 1;     // valid bit and destination

    // Configuration registers
    logic [START_W-1:0]     r_start;
    logic [ACCEPT_W-1:0]    r_accept;

    // Clearing sweep
    logic                   r_clearing;
    logic [SYMBOL_BITS-1:0] r_sweep;

    // Second stage: the beat whose table reads are in r_rd
    logic                   r_s1_valid;
    logic [ACTION_W-1:0]    r_s1_action;
    logic [SW-1:0]          r_s1_bank;
    logic [SW-1:0]          r_s1_dest;
    logic [SYMBOL_BITS-1:0] r_s1_addr;
    logic                   r_s1_route_ok;
    logic                   r_s1_sym_ok;
    logic                   r_s1_last;

    // Write made at the edge the stage-two beat read the table
    logic                   r_fw_we;
    logic [SW-1:0]          r_fw_bank;
    logic [SYMBOL_BITS-1:0] r_fw_addr;
    logic [SW-1:0]          r_fw_dest;

    // Search state
    logic [NUM_STATES-1:0]  r_live;
    logic                   r_found_flag;

    // Output register
    logic                   r_out_valid;
    logic                   r_hit;
    logic                   r_found;
    logic                   r_line_end;

    logic [EW-1:0]          r_rd [NUM_STATES];
    logic [EW-1:0]          w_ent [NUM_STATES];

    logic                   w_in_fire;
    logic                   w_hold;
    logic                   w_s1_text;
    logic                   w_s1_add;
    logic                   w_s1_adv;
    logic                   w_text_fire;
    logic                   w_add_we;
    logic                   w_sym_ok;
    logic                   w_route_ok;
    logic [NUM_STATES-1:0]  w_cur;
    logic [NUM_STATES-1:0]  w_next;
    logic [NUM_STATES-1:0]  w_acc;
    logic                   w_hit;
    logic [SYMBOL_BITS-1:0] w_wr_addr;
    logic [EW-1:0]          w_wr_data;

    assign w_s1_text   = r_s1_valid && (r_s1_action == ACT_TEXT);
    assign w_s1_add    = r_s1_valid && (r_s1_action == ACT_ADD);
    assign w_hold      = w_s1_text && r_out_valid && i_out_stall;
    assign w_s1_adv    = !w_hold;
    assign w_text_fire = w_s1_text && !w_hold;
    assign o_in_stall  = r_clearing || w_hold;
    assign w_in_fire   = i_in_valid && !o_in_stall;

    // Range checks: symbols must fit the table, states must exist.
    assign w_sym_ok   = (32'(i_symbol) >> SYMBOL_BITS) == 32'd0;
    assign w_route_ok = w_sym_ok && (32'(i_state_from) < NUM_STATES)
                        && (32'(i_state_to) < NUM_STATES);

    // A read issued at the same edge as the previous write misses it.
    always_comb begin
        for (int s = 0; s < NUM_STATES; s++) begin
            if (r_fw_we && (r_fw_bank == SW'(s)) && (r_fw_addr == r_s1_addr)) begin
                w_ent[s] = {1'b1, r_fw_dest};
            end else begin
                w_ent[s] = r_rd[s];
            end
        end
    end

    // First route wins: only an invalid entry is written.
    assign w_add_we = w_s1_add && r_s1_route_ok && !w_ent[r_s1_bank][SW];

    always_comb begin
        w_cur = r_live;
        if (32'(r_start) < NUM_STATES) begin
            w_cur = w_cur | (NUM_STATES'(1) << SW'(r_start));
        end
        w_next = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            if (w_cur[s] && w_ent[s][SW]) begin
                w_next = w_next | (NUM_STATES'(1) << w_ent[s][SW-1:0]);
            end
        end
        if (!r_s1_sym_ok) begin
            w_next = '0;
        end
    end

    // States that the mask does not cover are never accepting.
    assign w_acc = NUM_STATES'(r_accept);
    assign w_hit = (w_next & w_acc) != '0;

    assign w_wr_addr = r_clearing ? r_sweep : r_s1_addr;
    assign w_wr_data = r_clearing ? '0 : {1'b1, r_s1_dest};

    // One memory per state, all read at the byte address.
    for (genvar b = 0; b < NUM_STATES; b++) begin : g_bank
        logic [EW-1:0] mem [DEPTH];
        logic          w_we;

        assign w_we = r_clearing || (w_add_we && (r_s1_bank == SW'(b)));

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem[w_wr_addr] <= w_wr_data;
            end
            if (w_in_fire) begin
                r_rd[b] <= mem[i_symbol[SYMBOL_BITS-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_accept <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_STATE: r_start  <= i_cfg_data[START_W-1:0];
                CFG_ACCEPT_MASK: r_accept <= i_cfg_data[ACCEPT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_sweep    <= '0;
        end else if (r_clearing) begin
            r_sweep <= r_sweep + 1'b1;
            if (r_sweep == '1) begin
                r_clearing <= 1'b0;
            end
        end else if (w_in_fire && (i_action == ACT_CLEAR)) begin
            r_clearing <= 1'b1;
            r_sweep    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_we    <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_in_fire;
            r_fw_we    <= w_add_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_fw_bank <= r_s1_bank;
            r_fw_addr <= r_s1_addr;
            r_fw_dest <= r_s1_dest;
        end
        if (w_in_fire) begin
            r_s1_action   <= i_action;
            r_s1_bank     <= SW'(i_state_from);
            r_s1_dest     <= SW'(i_state_to);
            r_s1_addr     <= i_symbol[SYMBOL_BITS-1:0];
            r_s1_route_ok <= w_route_ok;
            r_s1_sym_ok   <= w_sym_ok;
            r_s1_last     <= i_line_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live       <= '0;
            r_found_flag <= 1'b0;
        end else if (w_text_fire) begin
            r_live       <= r_s1_last ? '0 : w_next;
            r_found_flag <= r_s1_last ? 1'b0 : (r_found_flag || w_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_text_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_text_fire) begin
            r_hit      <= w_hit;
            r_found    <= r_found_flag || w_hit;
            r_line_end <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_found     = r_found;
    assign o_line_end  = r_line_end;

endmodule

`default_nettype wire

// File: rtl/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks of the DFA substring search core, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfa_substring_search_core_assert.svh"

module dss_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              o_in_stall,
    input  wire  [dss_pkg::ACTION_W-1:0]     i_action,
    input  wire                              o_out_valid,
    input  wire                              i_out_stall,
    input  wire                              o_hit,
    input  wire                              o_found
);
    import dss_pkg::*;

    // A result beat waits until it is taken.
    `DSS_ASSERT_RST(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result beat dropped")

    // The table sweep after reset keeps the input closed.
    `DSS_ASSERT(a_reset_sweep, !i_rst_n |=> o_in_stall, "input open during reset sweep")

    // A clear beat starts a sweep at once.
    `DSS_ASSERT_RST(a_clear_sweep, i_in_valid && !o_in_stall && (i_action == ACT_CLEAR) |=> o_in_stall, "no sweep after clear")

    // A hit always sets the line flag in the same beat.
    `DSS_ASSERT_RST(a_hit_found, o_out_valid && o_hit |-> o_found, "hit without found")

endmodule

bind dfa_substring_search_core dss_checker u_dss_checker (.*);

`default_nettype wire
